/* hw/rtl/humidity_sensor_read_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// Humidity sensor read sequencer assertion macros
// Shorthand for clocked concurrent assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_READ_SEQUENCER_MACROS_SVH
`define HUMIDITY_SENSOR_READ_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define HSRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("humidity sensor read sequencer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define HSRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("humidity sensor read sequencer: next-cycle check failed");

`endif

/* hw/rtl/hsrs_pkg.sv */
// ----------------------------------------------------------------------------
// Humidity sensor read sequencer package
// Shared types, codes and constants for the read sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package hsrs_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEVICE_ADDRESS  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MEASURE_COMMAND = 1'd1;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [6:0]  DEVICE_ADDRESS_RST  = 7'h45;
   localparam logic [15:0] MEASURE_COMMAND_RST = 16'h2C06;

   // CRC-8 over each data word
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Fixed-point scaling
   localparam int TEMP_SPAN   = 17500;
   localparam int TEMP_OFFSET = 4500;
   localparam int HUM_SPAN    = 10000;
   localparam int FULL_SCALE  = 65535;

   // Stream widths
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   // Sequencer phase
   typedef enum logic [2:0] {
      PH_IDLE       = 3'b001,
      PH_WAIT_WRITE = 3'b010,
      PH_WAIT_READ  = 3'b100
   } phase_type;

   // Result action codes
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_WRITE   = 3'd1,
      ACT_READ    = 3'd2,
      ACT_VALID   = 3'd3,
      ACT_CRC_ERR = 3'd4
   } action_type;

endpackage

`default_nettype wire

/* hw/rtl/humidity_sensor_read_sequencer.sv */
// ----------------------------------------------------------------------------
// Humidity sensor read sequencer
// Steps a sensor through command write and 6-byte read, checks both data
// words with CRC-8 and scales the raw readings to hundredths.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser {nack, func}, tdata rx_frame
//   rsp      out  rsp_tvalid/rsp_tready  tuser action, tdata result fields
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle sustained while rsp_tready is high. An item passes an
// input register, then the phase step, CRC and scaling into the result
// register. The phase register advances as an item enters the result
// register. Synchronous reset returns to idle and the register reset values.
// A stalled result holds both stages; csr writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_read_sequencer
   import hsrs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // [47:0] rx_frame
   input  wire logic [REQ_USER_W-1:0]  req_tuser,   // [0] func, [1] nack
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [6:0] bus_address, [22:7] command_word, [37:23] temperature_centi,
   // [51:38] humidity_centi, [52] temp_crc_ok, [53] hum_crc_ok, [55:54] zero
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic [RSP_USER_W-1:0]       rsp_tuser,   // [2:0] action
   // configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // CRC-8 of one byte, continuing from crc
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Floor of x / 65535: estimate by a shift, fix by one compare
   function automatic logic [15:0] div_full_scale(input logic [30:0] x);
      logic [14:0] q0;
      logic [16:0] r0;
      q0 = x[30:16];
      r0 = {1'b0, x[15:0]} + {2'b00, q0};
      return {1'b0, q0} + ((r0 >= 17'(FULL_SCALE)) ? 16'd1 : 16'd0);
   endfunction

   // Configuration registers
   logic [6:0]  device_address_ff;
   logic [15:0] measure_command_ff;

   // Input stage
   logic        in_valid_ff;
   logic        in_func_ff;
   logic        in_nack_ff;
   logic [47:0] in_frame_ff;

   // Result stage
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   action_type            rsp_action_ff;
   action_type            action_in;

   phase_type phase_ff;
   phase_type phase_in;

   logic out_ready;
   logic out_load;

   logic [15:0] t_raw;
   logic [7:0]  t_crc;
   logic [15:0] h_raw;
   logic [7:0]  h_crc;
   logic        t_ok;
   logic        h_ok;
   logic [30:0] t_prod;
   logic [30:0] h_prod;
   logic [15:0] t_quot;
   logic [15:0] h_quot;
   logic [14:0] temp_val;
   logic [13:0] hum_val;

   logic [6:0]  addr_in;
   logic [15:0] cmd_in;
   logic [14:0] temp_in;
   logic [13:0] hum_in;
   logic        tok_in;
   logic        hok_in;

   // Handshakes: each stage moves when the one after it can take an item
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign out_load   = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;
   assign csr_ready  = 1'b1;

   // Take configuration writes; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff  <= DEVICE_ADDRESS_RST;
         measure_command_ff <= MEASURE_COMMAND_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DEVICE_ADDRESS:  device_address_ff  <= csr_data[6:0];
            REG_MEASURE_COMMAND: measure_command_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Capture the request item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff  <= req_tuser[0];
         in_nack_ff  <= req_tuser[1];
         in_frame_ff <= req_tdata;
      end
   end

   // Split the frame and check both words
   assign t_raw = in_frame_ff[47:32];
   assign t_crc = in_frame_ff[31:24];
   assign h_raw = in_frame_ff[23:8];
   assign h_crc = in_frame_ff[7:0];
   assign t_ok  = (crc8_byte(crc8_byte(CRC_INIT, t_raw[15:8]), t_raw[7:0]) == t_crc);
   assign h_ok  = (crc8_byte(crc8_byte(CRC_INIT, h_raw[15:8]), h_raw[7:0]) == h_crc);

   // Scale raw readings to hundredths
   assign t_prod   = {15'd0, t_raw} * 31'(TEMP_SPAN);
   assign h_prod   = {15'd0, h_raw} * 31'(HUM_SPAN);
   assign t_quot   = div_full_scale(t_prod);
   assign h_quot   = div_full_scale(h_prod);
   assign temp_val = t_quot[14:0] - 15'(TEMP_OFFSET);
   assign hum_val  = h_quot[13:0];

   // Phase step for the item in the input stage
   always_comb begin
      action_in = ACT_NONE;
      phase_in  = phase_ff;
      temp_in   = '0;
      hum_in    = '0;
      tok_in    = 1'b0;
      hok_in    = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (!in_func_ff) begin
               action_in = ACT_WRITE;
               phase_in  = PH_WAIT_WRITE;
            end
         end
         PH_WAIT_WRITE: begin
            if (in_func_ff) begin
               if (in_nack_ff) begin
                  action_in = ACT_WRITE;
               end else begin
                  action_in = ACT_READ;
                  phase_in  = PH_WAIT_READ;
               end
            end
         end
         PH_WAIT_READ: begin
            if (in_func_ff) begin
               if (in_nack_ff) begin
                  action_in = ACT_READ;
               end else begin
                  tok_in = t_ok;
                  hok_in = h_ok;
                  if (t_ok && h_ok) begin
                     action_in = ACT_VALID;
                     temp_in   = temp_val;
                     hum_in    = hum_val;
                     phase_in  = PH_IDLE;
                  end else begin
                     action_in = ACT_CRC_ERR;
                     phase_in  = PH_WAIT_WRITE;
                  end
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Address and command go out only with the transfers that use them
   assign addr_in = (action_in == ACT_WRITE || action_in == ACT_READ ||
                     action_in == ACT_CRC_ERR) ? device_address_ff : 7'd0;
   assign cmd_in  = (action_in == ACT_WRITE || action_in == ACT_CRC_ERR) ?
                    measure_command_ff : 16'd0;

   assign rsp_data_in = {2'b00, hok_in, tok_in, hum_in, temp_in, cmd_in, addr_in};

   // Advance the phase as the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (out_load) begin
         phase_ff <= phase_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_action_ff <= action_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_action_ff;

   // Short terms for the checks below
   logic        rsp_is_valid;
   logic        rsp_is_err;
   logic        rsp_crcs_ok;
   logic        in_stall;
   logic        load_valid;
   logic [49:0] in_item;

   assign rsp_is_valid = rsp_tvalid && (rsp_tuser == ACT_VALID);
   assign rsp_is_err   = rsp_tvalid && (rsp_tuser == ACT_CRC_ERR);
   assign rsp_crcs_ok  = rsp_tdata[52] && rsp_tdata[53];
   assign in_stall     = in_valid_ff && !out_ready;
   assign load_valid   = out_load && (action_in == ACT_VALID);
   assign in_item      = {in_frame_ff, in_func_ff, in_nack_ff};

`include "humidity_sensor_read_sequencer_macros.svh"

   // A valid reading always carries two good CRCs
   `HSRS_ASSERT_IMPL(a_valid_has_crc, clock, reset, rsp_is_valid, rsp_crcs_ok)
   // A CRC error always carries at least one failed check
   `HSRS_ASSERT_IMPL(a_err_has_fail, clock, reset, rsp_is_err, !rsp_crcs_ok)
   // A stalled input stage keeps its item
   `HSRS_ASSERT_NEXT(a_in_hold, clock, reset, in_stall, in_valid_ff && $stable(in_item))
   // After a reported reading the sequencer is idle
   `HSRS_ASSERT_NEXT(a_valid_idle, clock, reset, load_valid, phase_ff == PH_IDLE)

endmodule

`default_nettype wire
